>>> hdl/wsdp_pkg.sv
// Shared types, header constants and helpers for the WAV stream to DAC player.
package wsdp_pkg;

    // Header tags, first file byte in the lowest bits
    localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
    localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
    localparam logic [31:0] MAGIC_FMT  = 32'h2074_6D66;
    localparam logic [31:0] MAGIC_DATA = 32'h6174_6164;

    localparam logic [15:0] SAMPLE_OFFSET = 16'h8000;
    localparam logic [2:0]  SKIP_BYTES    = 3'd6;
    localparam logic [2:0]  MAX_VOLUME    = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_SAMPLE  = 2'd0;
    localparam logic [1:0] KIND_FORMAT  = 2'd1;
    localparam logic [1:0] KIND_NOWAVE  = 2'd2;
    localparam logic [1:0] KIND_BADBITS = 2'd3;

    // Play mode bits
    localparam int unsigned MODE_STEREO = 0;
    localparam int unsigned MODE_WIDE   = 1;

    typedef enum logic [13:0] {
        PH_WAIT  = 14'b00_0000_0000_0001,
        PH_RIFF  = 14'b00_0000_0000_0010,
        PH_RSIZE = 14'b00_0000_0000_0100,
        PH_WAVE  = 14'b00_0000_0000_1000,
        PH_FMT   = 14'b00_0000_0001_0000,
        PH_FSIZE = 14'b00_0000_0010_0000,
        PH_TAG   = 14'b00_0000_0100_0000,
        PH_CHAN  = 14'b00_0000_1000_0000,
        PH_RATE  = 14'b00_0001_0000_0000,
        PH_SKIP  = 14'b00_0010_0000_0000,
        PH_BITS  = 14'b00_0100_0000_0000,
        PH_SEEK  = 14'b00_1000_0000_0000,
        PH_DSIZE = 14'b01_0000_0000_0000,
        PH_PLAY  = 14'b10_0000_0000_0000
    } wsdp_phase_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] dac_value;
        logic        end_of_data;
        logic [31:0] riff_size;
        logic [31:0] format_chunk_size;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] bits_per_sample;
        logic [31:0] data_bytes;
    } wsdp_result_t;

    // Bytes in one frame for a play mode
    function automatic logic [2:0] frame_size(input logic [1:0] mode);
        logic [2:0] fs;
        fs = mode[MODE_STEREO] ? 3'd2 : 3'd1;
        return mode[MODE_WIDE] ? {fs[1:0], 1'b0} : fs;
    endfunction

    // Signed 16-bit sample made offset
    function automatic logic [15:0] sample16(input logic [7:0] lo, input logic [7:0] hi);
        return {hi, lo} ^ SAMPLE_OFFSET;
    endfunction

endpackage

>>> hdl/wsdp_parser.sv
// Header parser state and per-byte sample conversion for the WAV player.
module wsdp_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,         // process one byte this cycle
    input  logic [7:0]            data_byte,
    input  logic                  file_start,
    input  logic [2:0]            volume,
    output logic                  res_valid,
    output wsdp_pkg::wsdp_result_t res
);

    wsdp_pkg::wsdp_phase_t phase_reg, phase_next;
    logic [2:0]  byte_index_reg, byte_index_next;
    logic [31:0] riff_length_reg, riff_length_next;
    logic [31:0] fmt_length_reg, fmt_length_next;
    logic [15:0] format_code_reg, format_code_next;
    logic [15:0] channels_seen_reg, channels_seen_next;
    logic [31:0] rate_seen_reg, rate_seen_next;
    logic [15:0] depth_seen_reg, depth_seen_next;
    logic [1:0]  play_mode_reg, play_mode_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [23:0] frame_bytes_reg, frame_bytes_next;

    // Step logic: clear on file start, then handle the byte for the phase
    always_comb begin
        wsdp_pkg::wsdp_phase_t cur;
        logic [2:0]  bi_inc;
        logic [31:0] magic;
        logic [2:0]  fs;
        logic [15:0] v;
        logic [16:0] sum;
        logic [8:0]  sum8;

        cur                = file_start ? wsdp_pkg::PH_RIFF : phase_reg;
        phase_next         = cur;
        byte_index_next    = file_start ? 3'd0 : byte_index_reg;
        riff_length_next   = file_start ? 32'd0 : riff_length_reg;
        fmt_length_next    = file_start ? 32'd0 : fmt_length_reg;
        format_code_next   = file_start ? 16'd0 : format_code_reg;
        channels_seen_next = file_start ? 16'd0 : channels_seen_reg;
        rate_seen_next     = file_start ? 32'd0 : rate_seen_reg;
        depth_seen_next    = file_start ? 16'd0 : depth_seen_reg;
        play_mode_next     = file_start ? 2'd0 : play_mode_reg;
        bytes_left_next    = file_start ? 32'd0 : bytes_left_reg;
        frame_bytes_next   = file_start ? 24'd0 : frame_bytes_reg;

        bi_inc    = byte_index_next + 3'd1;
        fs        = wsdp_pkg::frame_size(play_mode_next);
        v         = '0;
        sum       = '0;
        sum8      = '0;
        res_valid = 1'b0;
        res.result_kind = wsdp_pkg::KIND_SAMPLE;
        res.dac_value   = '0;
        res.end_of_data = 1'b0;
        res.data_bytes  = '0;

        case (cur)
            wsdp_pkg::PH_RIFF:  magic = wsdp_pkg::MAGIC_RIFF;
            wsdp_pkg::PH_WAVE:  magic = wsdp_pkg::MAGIC_WAVE;
            wsdp_pkg::PH_FMT:   magic = wsdp_pkg::MAGIC_FMT;
            default:            magic = wsdp_pkg::MAGIC_DATA;
        endcase

        case (cur)
            // Check a magic word; drop to wait on the first wrong byte
            wsdp_pkg::PH_RIFF, wsdp_pkg::PH_WAVE, wsdp_pkg::PH_FMT: begin
                if (data_byte != magic[8*byte_index_next[1:0] +: 8]) begin
                    phase_next      = wsdp_pkg::PH_WAIT;
                    byte_index_next = 3'd0;
                    res_valid       = 1'b1;
                    res.result_kind = wsdp_pkg::KIND_NOWAVE;
                end else if (bi_inc >= 3'd4) begin
                    byte_index_next = 3'd0;
                    phase_next = (cur == wsdp_pkg::PH_RIFF) ? wsdp_pkg::PH_RSIZE :
                                 (cur == wsdp_pkg::PH_WAVE) ? wsdp_pkg::PH_FMT :
                                                              wsdp_pkg::PH_FSIZE;
                end else begin
                    byte_index_next = bi_inc;
                end
            end
            wsdp_pkg::PH_RSIZE: begin
                riff_length_next[8*byte_index_next[1:0] +: 8] =
                    riff_length_next[8*byte_index_next[1:0] +: 8] | data_byte;
                byte_index_next = (bi_inc >= 3'd4) ? 3'd0 : bi_inc;
                if (bi_inc >= 3'd4) phase_next = wsdp_pkg::PH_WAVE;
            end
            wsdp_pkg::PH_FSIZE: begin
                fmt_length_next[8*byte_index_next[1:0] +: 8] =
                    fmt_length_next[8*byte_index_next[1:0] +: 8] | data_byte;
                byte_index_next = (bi_inc >= 3'd4) ? 3'd0 : bi_inc;
                if (bi_inc >= 3'd4) phase_next = wsdp_pkg::PH_TAG;
            end
            wsdp_pkg::PH_TAG: begin
                format_code_next[8*byte_index_next[0] +: 8] =
                    format_code_next[8*byte_index_next[0] +: 8] | data_byte;
                byte_index_next = (bi_inc >= 3'd2) ? 3'd0 : bi_inc;
                if (bi_inc >= 3'd2) phase_next = wsdp_pkg::PH_CHAN;
            end
            wsdp_pkg::PH_CHAN: begin
                channels_seen_next[8*byte_index_next[0] +: 8] =
                    channels_seen_next[8*byte_index_next[0] +: 8] | data_byte;
                byte_index_next = (bi_inc >= 3'd2) ? 3'd0 : bi_inc;
                if (bi_inc >= 3'd2) begin
                    play_mode_next = (channels_seen_next == 16'd2) ? 2'd1 : 2'd0;
                    phase_next     = wsdp_pkg::PH_RATE;
                end
            end
            wsdp_pkg::PH_RATE: begin
                rate_seen_next[8*byte_index_next[1:0] +: 8] =
                    rate_seen_next[8*byte_index_next[1:0] +: 8] | data_byte;
                byte_index_next = (bi_inc >= 3'd4) ? 3'd0 : bi_inc;
                if (bi_inc >= 3'd4) phase_next = wsdp_pkg::PH_SKIP;
            end
            // Skip byte rate and block align
            wsdp_pkg::PH_SKIP: begin
                byte_index_next = (bi_inc >= wsdp_pkg::SKIP_BYTES) ? 3'd0 : bi_inc;
                if (bi_inc >= wsdp_pkg::SKIP_BYTES) phase_next = wsdp_pkg::PH_BITS;
            end
            // Read bit depth; only 8 and 16 go on
            wsdp_pkg::PH_BITS: begin
                depth_seen_next[8*byte_index_next[0] +: 8] =
                    depth_seen_next[8*byte_index_next[0] +: 8] | data_byte;
                byte_index_next = (bi_inc >= 3'd2) ? 3'd0 : bi_inc;
                if (bi_inc >= 3'd2) begin
                    if (depth_seen_next == 16'd16) begin
                        play_mode_next[wsdp_pkg::MODE_WIDE] = 1'b1;
                        phase_next = wsdp_pkg::PH_SEEK;
                    end else if (depth_seen_next != 16'd8) begin
                        phase_next      = wsdp_pkg::PH_WAIT;
                        res_valid       = 1'b1;
                        res.result_kind = wsdp_pkg::KIND_BADBITS;
                    end else begin
                        phase_next = wsdp_pkg::PH_SEEK;
                    end
                end
            end
            // Search for the data tag; a wrong byte restarts the match
            wsdp_pkg::PH_SEEK: begin
                if (data_byte != magic[8*byte_index_next[1:0] +: 8]) begin
                    byte_index_next = 3'd0;
                end else if (bi_inc >= 3'd4) begin
                    byte_index_next = 3'd0;
                    phase_next      = wsdp_pkg::PH_DSIZE;
                end else begin
                    byte_index_next = bi_inc;
                end
            end
            // Read data size and report the format
            wsdp_pkg::PH_DSIZE: begin
                bytes_left_next[8*byte_index_next[1:0] +: 8] =
                    bytes_left_next[8*byte_index_next[1:0] +: 8] | data_byte;
                byte_index_next = (bi_inc >= 3'd4) ? 3'd0 : bi_inc;
                if (bi_inc >= 3'd4) begin
                    res_valid        = 1'b1;
                    res.result_kind  = wsdp_pkg::KIND_FORMAT;
                    res.data_bytes   = bytes_left_next;
                    frame_bytes_next = '0;
                    phase_next = (bytes_left_next < {29'd0, fs}) ?
                                 wsdp_pkg::PH_WAIT : wsdp_pkg::PH_PLAY;
                end
            end
            // Gather a frame, then convert and scale it
            wsdp_pkg::PH_PLAY: begin
                bytes_left_next = bytes_left_next - 32'd1;
                if (bi_inc < fs) begin
                    byte_index_next  = bi_inc;
                    frame_bytes_next = {frame_bytes_next[15:0], data_byte};
                end else begin
                    case (play_mode_next)
                        2'd0: v = {data_byte, 8'd0};
                        2'd1: begin
                            sum8 = {1'b0, frame_bytes_next[7:0]} + {1'b0, data_byte};
                            v    = {sum8, 7'd0};
                        end
                        2'd2: v = wsdp_pkg::sample16(frame_bytes_next[7:0], data_byte);
                        default: begin
                            sum = {1'b0, wsdp_pkg::sample16(frame_bytes_next[23:16],
                                                            frame_bytes_next[15:8])}
                                + {1'b0, wsdp_pkg::sample16(frame_bytes_next[7:0],
                                                            data_byte)};
                            v   = sum[16:1];
                        end
                    endcase
                    byte_index_next  = 3'd0;
                    frame_bytes_next = '0;
                    res_valid        = 1'b1;
                    res.result_kind  = wsdp_pkg::KIND_SAMPLE;
                    res.dac_value    = v >> (wsdp_pkg::MAX_VOLUME - volume);
                    res.end_of_data  = (bytes_left_next < {29'd0, fs});
                    if (res.end_of_data) phase_next = wsdp_pkg::PH_WAIT;
                end
            end
            default: begin
                // Waiting: ignore bytes until a file start
            end
        endcase

        res.riff_size         = riff_length_next;
        res.format_chunk_size = fmt_length_next;
        res.format_tag        = format_code_next;
        res.channel_count     = channels_seen_next;
        res.rate_hz           = rate_seen_next;
        res.bits_per_sample   = depth_seen_next;
    end

    // Advance parser state on each processed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= wsdp_pkg::PH_WAIT;
            byte_index_reg    <= '0;
            riff_length_reg   <= '0;
            fmt_length_reg    <= '0;
            format_code_reg   <= '0;
            channels_seen_reg <= '0;
            rate_seen_reg     <= '0;
            depth_seen_reg    <= '0;
            play_mode_reg     <= '0;
            bytes_left_reg    <= '0;
            frame_bytes_reg   <= '0;
        end else if (step) begin
            phase_reg         <= phase_next;
            byte_index_reg    <= byte_index_next;
            riff_length_reg   <= riff_length_next;
            fmt_length_reg    <= fmt_length_next;
            format_code_reg   <= format_code_next;
            channels_seen_reg <= channels_seen_next;
            rate_seen_reg     <= rate_seen_next;
            depth_seen_reg    <= depth_seen_next;
            play_mode_reg     <= play_mode_next;
            bytes_left_reg    <= bytes_left_next;
            frame_bytes_reg   <= frame_bytes_next;
        end
    end

endmodule

>>> hdl/wav_stream_to_dac_player_top.sv
// Top level of the WAV stream to DAC player: input register, parser, result register.
// A result passes through the input register and then the result register before it
// shows on m_tvalid. One byte beat per cycle unless a result waits on m_tready;
// the parser step lies between the input register and the result register.
// Reset (aresetn low, synchronous) empties both registers and returns the parser
// to waiting for a file start with all header fields cleared.
module wav_stream_to_dac_player_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [7:0] data_byte, [10:8] volume, rest zero
    input  logic         s_tuser,   // [0] file_start
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // [15:0] dac_value, [47:16] riff_size,
                                    // [79:48] format_chunk_size, [95:80] format_tag,
                                    // [111:96] channel_count, [143:112] rate_hz,
                                    // [159:144] bits_per_sample, [191:160] data_bytes
    output logic [1:0]   m_tuser,   // [1:0] result_kind
    output logic         m_tlast    // end_of_data
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic [2:0] in_vol_reg;
    logic       out_valid_reg, out_valid_next;
    wsdp_pkg::wsdp_result_t out_res_reg;

    logic                   advance;
    logic                   s_take;
    logic                   res_valid;
    wsdp_pkg::wsdp_result_t res;

    // Move a byte into the parser when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    wsdp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .data_byte  (in_byte_reg),
        .file_start (in_start_reg),
        .volume     (in_vol_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Hold or refill the valid flags
    always_comb begin
        in_valid_next  = s_take || (in_valid_reg && !advance);
        out_valid_next = advance ? res_valid : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input beat payload
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg  <= s_tdata[7:0];
            in_vol_reg   <= s_tdata[10:8];
            in_start_reg <= s_tuser;
        end
    end

    // Load a new result beat
    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.result_kind;
    assign m_tlast  = out_res_reg.end_of_data;
    assign m_tdata  = {out_res_reg.data_bytes,
                       out_res_reg.bits_per_sample,
                       out_res_reg.rate_hz,
                       out_res_reg.channel_count,
                       out_res_reg.format_tag,
                       out_res_reg.format_chunk_size,
                       out_res_reg.riff_size,
                       out_res_reg.dac_value};

endmodule

>>> tb/wav_stream_to_dac_player_top_tb.sv
// Self-checking testbench for the WAV stream to DAC player: WAV files in, results out.
module wav_stream_to_dac_player_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STIM_BYTES  = 1950;
    localparam int unsigned QUIET_TAIL  = 150;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned HOLD_AFTER  = 600;
    localparam int unsigned STALL_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
        logic [2:0] volume;
    } wav_beat_t;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata  = '0;   // [7:0] data_byte, [10:8] volume, rest zero
    logic         s_tuser  = 1'b0; // [0] file_start
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;         // [15:0] dac_value, [47:16] riff_size,
                                   // [79:48] format_chunk_size, [95:80] format_tag,
                                   // [111:96] channel_count, [143:112] rate_hz,
                                   // [159:144] bits_per_sample, [191:160] data_bytes
    logic [1:0]   m_tuser;         // [1:0] result_kind
    logic         m_tlast;         // end_of_data

    wav_beat_t              wav_bytes_to_send[$];
    wsdp_pkg::wsdp_result_t outputs_due[$];

    int unsigned bytes_accepted = 0;
    int unsigned mismatches     = 0;
    int unsigned idle_cycles    = 0;
    int unsigned send_gap       = 0;
    int unsigned take_gap       = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;
    bit          byte_taken     = 1'b0;

    // Parser state mirrored from the block
    wsdp_pkg::wsdp_phase_t wav_phase;
    logic [2:0]  hdr_pos;
    logic [31:0] riff_len, fmt_len, tag_val, chan_val, rate_val, depth_val, left_bytes;
    logic [1:0]  mode_bits;
    logic [23:0] held_bytes;

    wav_stream_to_dac_player_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void clear_wav_header();
        hdr_pos    = '0;
        riff_len   = '0;
        fmt_len    = '0;
        tag_val    = '0;
        chan_val   = '0;
        rate_val   = '0;
        depth_val  = '0;
        mode_bits  = '0;
        left_bytes = '0;
        held_bytes = '0;
    endfunction

    // Fold one byte into a little-endian header field; true once the field is whole
    function automatic bit gather_le(inout logic [31:0] acc, input logic [7:0] b,
                                     input int unsigned len);
        acc = acc | (32'(b) << (8 * hdr_pos[1:0]));
        hdr_pos++;
        if (hdr_pos >= len) begin
            hdr_pos = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic wsdp_pkg::wsdp_result_t player_result(input logic [1:0] kind,
                                                             input logic [15:0] dac,
                                                             input logic last,
                                                             input logic [31:0] dsize);
        wsdp_pkg::wsdp_result_t res;
        res.result_kind       = kind;
        res.dac_value         = dac;
        res.end_of_data       = last;
        res.riff_size         = riff_len;
        res.format_chunk_size = fmt_len;
        res.format_tag        = tag_val[15:0];
        res.channel_count     = chan_val[15:0];
        res.rate_hz           = rate_val;
        res.bits_per_sample   = depth_val[15:0];
        res.data_bytes        = dsize;
        return res;
    endfunction

    // Advance the parser by one byte and work out the result it causes, if any
    function automatic void parse_wav_byte(input logic [7:0] b, input logic start,
                                           input logic [2:0] vol, output bit emitted,
                                           output wsdp_pkg::wsdp_result_t res);
        logic [31:0] tag_word;
        logic [31:0] level;
        int unsigned fbytes;
        bit          last;
        emitted = 1'b0;
        res     = '0;
        fbytes  = (1 + mode_bits[wsdp_pkg::MODE_STEREO]) * (1 + mode_bits[wsdp_pkg::MODE_WIDE]);
        if (start) begin
            clear_wav_header();
            wav_phase = wsdp_pkg::PH_RIFF;
        end
        case (wav_phase)
            wsdp_pkg::PH_RIFF, wsdp_pkg::PH_WAVE, wsdp_pkg::PH_FMT: begin
                tag_word = (wav_phase == wsdp_pkg::PH_RIFF) ? wsdp_pkg::MAGIC_RIFF :
                           (wav_phase == wsdp_pkg::PH_WAVE) ? wsdp_pkg::MAGIC_WAVE :
                                                              wsdp_pkg::MAGIC_FMT;
                if (b != tag_word[8 * hdr_pos[1:0] +: 8]) begin
                    wav_phase = wsdp_pkg::PH_WAIT;
                    hdr_pos   = '0;
                    emitted   = 1'b1;
                    res       = player_result(wsdp_pkg::KIND_NOWAVE, '0, 1'b0, '0);
                end else begin
                    hdr_pos++;
                    if (hdr_pos == 3'd4) begin
                        hdr_pos   = '0;
                        wav_phase = (wav_phase == wsdp_pkg::PH_RIFF) ? wsdp_pkg::PH_RSIZE :
                                    (wav_phase == wsdp_pkg::PH_WAVE) ? wsdp_pkg::PH_FMT :
                                                                       wsdp_pkg::PH_FSIZE;
                    end
                end
            end
            wsdp_pkg::PH_RSIZE: if (gather_le(riff_len, b, 4)) wav_phase = wsdp_pkg::PH_WAVE;
            wsdp_pkg::PH_FSIZE: if (gather_le(fmt_len, b, 4)) wav_phase = wsdp_pkg::PH_TAG;
            wsdp_pkg::PH_TAG:   if (gather_le(tag_val, b, 2)) wav_phase = wsdp_pkg::PH_CHAN;
            wsdp_pkg::PH_CHAN: begin
                if (gather_le(chan_val, b, 2)) begin
                    mode_bits = '0;
                    mode_bits[wsdp_pkg::MODE_STEREO] = (chan_val == 32'd2);
                    wav_phase = wsdp_pkg::PH_RATE;
                end
            end
            wsdp_pkg::PH_RATE:  if (gather_le(rate_val, b, 4)) wav_phase = wsdp_pkg::PH_SKIP;
            wsdp_pkg::PH_SKIP: begin
                hdr_pos++;
                if (hdr_pos == wsdp_pkg::SKIP_BYTES) begin
                    hdr_pos   = '0;
                    wav_phase = wsdp_pkg::PH_BITS;
                end
            end
            wsdp_pkg::PH_BITS: begin
                if (gather_le(depth_val, b, 2)) begin
                    if (depth_val == 32'd16) begin
                        mode_bits[wsdp_pkg::MODE_WIDE] = 1'b1;
                        wav_phase = wsdp_pkg::PH_SEEK;
                    end else if (depth_val != 32'd8) begin
                        wav_phase = wsdp_pkg::PH_WAIT;
                        emitted   = 1'b1;
                        res       = player_result(wsdp_pkg::KIND_BADBITS, '0, 1'b0, '0);
                    end else begin
                        wav_phase = wsdp_pkg::PH_SEEK;
                    end
                end
            end
            // Naive search: a wrong byte drops the partial match and is not retried
            wsdp_pkg::PH_SEEK: begin
                if (b != wsdp_pkg::MAGIC_DATA[8 * hdr_pos[1:0] +: 8]) begin
                    hdr_pos = '0;
                end else begin
                    hdr_pos++;
                    if (hdr_pos == 3'd4) begin
                        hdr_pos   = '0;
                        wav_phase = wsdp_pkg::PH_DSIZE;
                    end
                end
            end
            wsdp_pkg::PH_DSIZE: begin
                if (gather_le(left_bytes, b, 4)) begin
                    emitted    = 1'b1;
                    res        = player_result(wsdp_pkg::KIND_FORMAT, '0, 1'b0, left_bytes);
                    held_bytes = '0;
                    wav_phase  = (left_bytes < fbytes) ? wsdp_pkg::PH_WAIT : wsdp_pkg::PH_PLAY;
                end
            end
            wsdp_pkg::PH_PLAY: begin
                left_bytes--;
                hdr_pos++;
                if (hdr_pos < fbytes) begin
                    held_bytes = {held_bytes[15:0], b};
                end else begin
                    case (mode_bits)
                        2'b00: level = {16'h0000, b, 8'h00};
                        2'b01: level = (32'(held_bytes[7:0]) + 32'(b)) << 7;
                        2'b10: level = 32'({b, held_bytes[7:0]} ^ wsdp_pkg::SAMPLE_OFFSET);
                        default: begin
                            level = (32'({held_bytes[15:8], held_bytes[23:16]}
                                         ^ wsdp_pkg::SAMPLE_OFFSET)
                                     + 32'({b, held_bytes[7:0]}
                                           ^ wsdp_pkg::SAMPLE_OFFSET)) >> 1;
                        end
                    endcase
                    level      = level >> (wsdp_pkg::MAX_VOLUME - vol);
                    hdr_pos    = '0;
                    held_bytes = '0;
                    last       = (left_bytes < fbytes);
                    if (last) wav_phase = wsdp_pkg::PH_WAIT;
                    emitted = 1'b1;
                    res     = player_result(wsdp_pkg::KIND_SAMPLE, level[15:0], last, '0);
                end
            end
            default: begin
                // waiting for a file start: drop the byte
            end
        endcase
    endfunction

    function automatic void queue_beat(input logic [7:0] b, input logic start,
                                       input logic [2:0] vol);
        wav_beat_t beat;
        beat.data_byte  = b;
        beat.file_start = start;
        beat.volume     = vol;
        wav_bytes_to_send.push_back(beat);
    endfunction

    function automatic void add_le(ref logic [7:0] img[$], input logic [31:0] word,
                                   input int unsigned count);
        for (int unsigned k = 0; k < count; k++) img.push_back(word[8 * k +: 8]);
    endfunction

    // Build one WAV file with random content, mostly well formed, and queue its bytes
    function automatic void queue_wav_file();
        logic [7:0]  img[$];
        logic [31:0] dsize;
        logic [31:0] field;
        int unsigned pick, k, sendlen, restart_at;
        bit          huge_size;
        add_le(img, wsdp_pkg::MAGIC_RIFF, 4);
        add_le(img, $urandom, 4);
        add_le(img, wsdp_pkg::MAGIC_WAVE, 4);
        add_le(img, wsdp_pkg::MAGIC_FMT, 4);
        add_le(img, ($urandom_range(0, 4) == 0) ? $urandom : 32'd16, 4);
        add_le(img, ($urandom_range(0, 4) == 0) ? $urandom : 32'd1, 2);
        pick  = $urandom_range(0, 9);
        field = (pick < 4) ? 32'd1 : (pick < 8) ? 32'd2 : $urandom;
        add_le(img, field, 2);
        add_le(img, $urandom, 4);
        // bytes the parser skips
        add_le(img, $urandom, 4);
        add_le(img, $urandom, 2);
        pick  = $urandom_range(0, 9);
        field = (pick < 4) ? 32'd8 : (pick < 8) ? 32'd16 : $urandom;
        add_le(img, field, 2);

        // Optional filler before the data mark, rich in partial marks
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 10)) begin
                k = $urandom_range(0, 3);
                img.push_back($urandom_range(0, 1) ? wsdp_pkg::MAGIC_DATA[8 * k +: 8]
                                                   : 8'($urandom));
            end
        end

        if ($urandom_range(0, 9) != 0) begin
            add_le(img, wsdp_pkg::MAGIC_DATA, 4);
            pick      = $urandom_range(0, 19);
            huge_size = 1'b0;
            if (pick < 2) begin
                dsize = 32'd0;
            end else if (pick < 4) begin
                dsize = $urandom_range(1, 3);
            end else if (pick < 17) begin
                dsize = $urandom_range(4, 32);
            end else begin
                dsize     = $urandom;
                huge_size = 1'b1;
            end
            add_le(img, dsize, 4);
            sendlen = huge_size ? $urandom_range(4, 24) : dsize + $urandom_range(0, 3);
            repeat (sendlen) begin
                pick = $urandom_range(0, 7);
                img.push_back((pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom));
            end
        end else begin
            repeat ($urandom_range(1, 6)) img.push_back(8'($urandom));
        end

        // Break one magic byte now and then
        if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(0, 11);
            if (k >= 4) k = k + 4;
            img[k] = img[k] ^ 8'($urandom_range(1, 255));
        end

        restart_at = ($urandom_range(0, 19) == 0) ? $urandom_range(1, img.size() - 1) : 0;
        foreach (img[i]) queue_beat(img[i], (i == 0) || (i == restart_at),
                                    3'($urandom_range(0, 7)));

        // Stray bytes between files
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 4)) queue_beat(8'($urandom), 1'b0,
                                                     3'($urandom_range(0, 7)));
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
        end
    endfunction

    // Stimulus, reset and end of run
    initial begin : stimulus
        wav_phase = wsdp_pkg::PH_WAIT;
        clear_wav_header();

        // stray bytes while waiting, then a bad first byte
        queue_beat(8'h00, 1'b0, 3'd0);
        queue_beat(8'hFF, 1'b0, 3'd7);
        queue_beat(8'hFF, 1'b1, 3'd7);
        // good RIFF with an all-ones size, broken WAVE tag
        for (int i = 0; i < 4; i++) queue_beat(wsdp_pkg::MAGIC_RIFF[8 * i +: 8], i == 0, 3'd0);
        for (int i = 0; i < 4; i++) queue_beat(8'hFF, 1'b0, 3'd7);
        for (int i = 0; i < 3; i++) queue_beat(wsdp_pkg::MAGIC_WAVE[8 * i +: 8], 1'b0, 3'd3);
        queue_beat(8'h00, 1'b0, 3'd4);
        // restart on a good first byte, then fail on the second
        queue_beat(wsdp_pkg::MAGIC_RIFF[7:0], 1'b1, 3'd1);
        queue_beat(wsdp_pkg::MAGIC_RIFF[7:0], 1'b1, 3'd6);
        queue_beat(8'h00, 1'b0, 3'd2);

        while (wav_bytes_to_send.size() < STIM_BYTES) queue_wav_file();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (wav_bytes_to_send.size() != 0 || s_tvalid) @(posedge aclk);
        while (outputs_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Sample each accepted byte beat and predict its result
    always @(posedge aclk) begin : byte_monitor
        bit                     emitted;
        wsdp_pkg::wsdp_result_t res;
        byte_taken = 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            byte_taken = 1'b1;
            bytes_accepted++;
            parse_wav_byte(s_tdata[7:0], s_tuser, s_tdata[10:8], emitted, res);
            if (emitted) outputs_due.push_back(res);
        end
    end

    // Offer byte beats, with random idle bursts except near the end
    always @(negedge aclk) begin : byte_sender
        wav_beat_t beat;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !byte_taken) begin
            // hold the offered beat until it is taken
        end else if (send_gap != 0) begin
            send_gap--;
            s_tvalid <= 1'b0;
        end else if (wav_bytes_to_send.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (wav_bytes_to_send.size() > QUIET_TAIL && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(0, 9);
            s_tvalid <= 1'b0;
        end else begin
            beat = wav_bytes_to_send.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {5'b0, beat.volume, beat.data_byte};
            s_tuser  <= beat.file_start;
        end
    end

    // Drive m_tready: one long hold-off to back up the block, and short random stalls
    always @(negedge aclk) begin : result_taker
        logic ready;
        ready = 1'b1;
        if (hold_left != 0) begin
            hold_left--;
            ready = 1'b0;
        end else if (!hold_done && bytes_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            ready     = 1'b0;
        end else if (take_gap != 0) begin
            take_gap--;
            ready = 1'b0;
        end else if (wav_bytes_to_send.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
            take_gap = $urandom_range(0, 9);
            ready    = 1'b0;
        end
        m_tready <= ready;
    end

    // Compare each result beat with the oldest prediction
    always @(posedge aclk) begin : result_checker
        wsdp_pkg::wsdp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (outputs_due.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected result, expected none, got kind %0d dac 0x%0h",
                         $time, m_tuser, m_tdata[15:0]);
            end else begin
                want = outputs_due.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(m_tuser));
                check_field("dac_value", 32'(want.dac_value), 32'(m_tdata[15:0]));
                check_field("end_of_data", 32'(want.end_of_data), 32'(m_tlast));
                check_field("riff_size", want.riff_size, m_tdata[47:16]);
                check_field("format_chunk_size", want.format_chunk_size, m_tdata[79:48]);
                check_field("format_tag", 32'(want.format_tag), 32'(m_tdata[95:80]));
                check_field("channel_count", 32'(want.channel_count), 32'(m_tdata[111:96]));
                check_field("rate_hz", want.rate_hz, m_tdata[143:112]);
                check_field("bits_per_sample", 32'(want.bits_per_sample),
                            32'(m_tdata[159:144]));
                check_field("data_bytes", want.data_bytes, m_tdata[191:160]);
            end
        end
    end

    // Stop the run when neither side has moved a beat for too long
    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

>>> sim.f
hdl/wsdp_pkg.sv
hdl/wsdp_parser.sv
hdl/wav_stream_to_dac_player_top.sv
tb/wav_stream_to_dac_player_top_tb.sv
